### sv/b64dec_pkg.sv
package b64dec_pkg;

    // Request queue between front and back. Depth must be a power of two
    // so the pointers wrap on their own.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_URL   = 2'd0;
    localparam logic [1:0] CFG_MODE  = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    // last_chunk_mode codes (code 3 acts as loose)
    localparam logic [1:0] MODE_LOOSE  = 2'd0;
    localparam logic [1:0] MODE_STRICT = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;

    // Item and result codes
    localparam logic CMD_CHAR    = 1'b0;
    localparam logic CMD_END     = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    // Characters
    localparam logic [15:0] CH_PAD   = 16'h003D;  // '='
    localparam logic [15:0] CH_TAB   = 16'h0009;
    localparam logic [15:0] CH_LF    = 16'h000A;
    localparam logic [15:0] CH_FF    = 16'h000C;
    localparam logic [15:0] CH_CR    = 16'h000D;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_UP_A  = 16'h0041;
    localparam logic [15:0] CH_UP_Z  = 16'h005A;
    localparam logic [15:0] CH_LO_A  = 16'h0061;
    localparam logic [15:0] CH_LO_Z  = 16'h007A;
    localparam logic [15:0] CH_D0    = 16'h0030;
    localparam logic [15:0] CH_D9    = 16'h0039;
    localparam logic [15:0] CH_PLUS  = 16'h002B;
    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_UNDER = 16'h005F;

    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;
    localparam logic [5:0] LOW4_MASK = 6'h0F;
    localparam logic [5:0] LOW2_MASK = 6'h03;

    // One request: up to three data bytes, then an optional finish report.
    typedef struct packed {
        logic [1:0]       nbytes;
        logic [2:0][7:0]  bytes;
        logic             fin;
        logic             failed;
        logic [31:0]      err_pos;
        logic [31:0]      rd_count;
        logic [31:0]      total;
    } job_t;

endpackage

### sv/base64_chunked_decoder_with_limits_top.sv
// Streaming base64 decoder, standard or URL-safe alphabet.
//
// Item channel (item_valid / item_stall): one request per cycle unless stalled, either a
// UTF-16 code unit (cmd = 0, ch) or an end-of-string marker (cmd = 1).
// Result channel (result_valid / result_stall): data bytes (kind = 0) and
// one finish report per string (kind = 1, last = 1) with failed flag, error
// position, committed read count and byte total.
// Config port: cfg_we / cfg_index / cfg_data; index 0 url_alphabet,
// 1 last_chunk_mode, 2 byte_limit. Write only while the block is idle.
//
// Throughput: one item per cycle while the request queue has room. The
// front decodes each item in its accept cycle and pushes at most one
// request (up to three bytes plus a finish report) into a 4-deep queue.
// The back drains a request at one result per cycle while result_stall is
// low, so a chunk-completing item yields three or four results; four
// characters per chunk keep the output side ahead on plain text.
// Path: an accepted item's first result passes the queue entry, then the output register.
// Stall: result_stall holds the output register; the queue absorbs up to
// four requests, then item_stall rises.
// Reset: asynchronous, clears config to defaults, string state and queue.
module base64_chunked_decoder_with_limits_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        cmd,
    input  logic [15:0] ch,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic        failed,
    output logic [31:0] error_position,
    output logic [31:0] read_count,
    output logic [31:0] bytes_total,
    output logic        last
);
    import b64dec_pkg::*;

    logic              accept;
    logic              job_push;
    job_t              job;
    job_t              head;
    logic              q_empty, q_full, q_pop;
    logic [QCNT_W-1:0] q_count;

    // stall on a full queue regardless of whether the item makes a request
    assign item_stall = q_full;
    assign accept     = item_valid && !item_stall;

    b64dec_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (cmd),
        .ch        (ch),
        .job_push  (job_push),
        .job       (job)
    );

    b64dec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full),
        .count    (q_count)
    );

    b64dec_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (q_empty),
        .pop            (q_pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .failed         (failed),
        .error_position (error_position),
        .read_count     (read_count),
        .bytes_total    (bytes_total),
        .last           (last)
    );

    // A request is never dropped at a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(job_push && q_full))
        else $error("request pushed into full queue");

    // Every queued request carries at least one result.
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.fin || job.nbytes != 2'd0))
        else $error("empty request pushed");

    // Occupancy moves by push/pop only.
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!job_push && !q_pop) |=> $stable(q_count))
        else $error("queue count changed without push or pop");

    // The back only drains a request while a finish or byte is pending.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

endmodule

### sv/b64dec_front.sv
module b64dec_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  accept,
    input  logic                  cmd,
    input  logic [15:0]           ch,
    output logic                  job_push,
    output b64dec_pkg::job_t      job
);
    import b64dec_pkg::*;

    typedef enum logic [3:0] {
        PH_COLLECT  = 4'b0001,
        PH_WANT_PAD = 4'b0010,
        PH_AFTER    = 4'b0100,
        PH_DONE     = 4'b1000
    } phase_t;

    function automatic logic [6:0] sextet_of(input logic [15:0] c, input logic url);
        logic [15:0] t;
        logic [6:0]  r;
        begin
            r = 7'h40;
            t = 16'd0;
            if (c >= CH_UP_A && c <= CH_UP_Z)
            begin
                t = c - CH_UP_A;
                r = {1'b0, t[5:0]};
            end
            else if (c >= CH_LO_A && c <= CH_LO_Z)
            begin
                t = c - CH_LO_A + 16'd26;
                r = {1'b0, t[5:0]};
            end
            else if (c >= CH_D0 && c <= CH_D9)
            begin
                t = c - CH_D0 + 16'd52;
                r = {1'b0, t[5:0]};
            end
            else if (url && c == CH_MINUS)
            begin
                r = {1'b0, SEXTET_62};
            end
            else if (url && c == CH_UNDER)
            begin
                r = {1'b0, SEXTET_63};
            end
            else if (!url && c == CH_PLUS)
            begin
                r = {1'b0, SEXTET_62};
            end
            else if (!url && c == CH_SLASH)
            begin
                r = {1'b0, SEXTET_63};
            end
            return r;
        end
    endfunction

    logic            url_reg;
    logic [1:0]      mode_reg;
    logic [31:0]     limit_reg;

    phase_t          phase_reg, phase_next;
    logic [1:0]      fill_reg, fill_next;
    logic [2:0][5:0] store_reg, store_next;
    logic [31:0]     pos_reg, pos_next;
    logic [31:0]     committed_reg, committed_next;
    logic [31:0]     emitted_reg, emitted_next;

    logic [31:0]     room;
    logic [31:0]     pos_inc;
    logic [31:0]     emitted_plus3;
    logic [6:0]      sx;
    logic            is_space;
    logic            is_pad;
    logic            stop_mode;
    logic [1:0]      part_nb;
    logic            extra_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            url_reg   <= 1'b0;
            mode_reg  <= MODE_LOOSE;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_URL:   url_reg   <= cfg_data[0];
                CFG_MODE:  mode_reg  <= cfg_data[1:0];
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        room          = limit_reg - emitted_reg;
        pos_inc       = pos_reg + 32'd1;
        emitted_plus3 = emitted_reg + 32'd3;
        sx            = sextet_of(ch, url_reg);
        is_space      = (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_FF) ||
                        (ch == CH_CR) || (ch == CH_SPACE);
        is_pad        = (ch == CH_PAD);
        stop_mode     = (mode_reg == MODE_STOP);
        part_nb       = (fill_reg == 2'd3) ? 2'd2 : 2'd1;
        extra_bits    = (fill_reg == 2'd2) ? ((store_reg[1] & LOW4_MASK) != 6'd0)
                                           : ((store_reg[2] & LOW2_MASK) != 6'd0);

        phase_next     = phase_reg;
        fill_next      = fill_reg;
        store_next     = store_reg;
        pos_next       = pos_reg;
        committed_next = committed_reg;
        emitted_next   = emitted_reg;

        job          = '0;
        job.err_pos  = pos_reg;
        job.total    = emitted_reg;
        job.rd_count = committed_reg;
        job.bytes[0] = {store_reg[0], store_reg[1][5:4]};
        job.bytes[1] = {store_reg[1][3:0], store_reg[2][5:2]};
        job.bytes[2] = {store_reg[2][1:0], sx[5:0]};

        if (cmd == CMD_CHAR)
        begin
            case (phase_reg)
                PH_DONE: ;
                PH_AFTER:
                begin
                    if (is_space)
                    begin
                        pos_next = pos_inc;
                    end
                    else
                    begin
                        job.fin    = 1'b1;
                        job.failed = 1'b1;
                    end
                end
                PH_WANT_PAD:
                begin
                    if (is_space || is_pad)
                    begin
                        pos_next = pos_inc;
                        if (is_pad) phase_next = PH_AFTER;
                    end
                    else
                    begin
                        job.fin    = 1'b1;
                        job.failed = !stop_mode;
                    end
                end
                PH_COLLECT:
                begin
                    if (limit_reg == 32'd0)
                    begin
                        job.fin      = 1'b1;
                        job.rd_count = 32'd0;
                    end
                    else if (is_space)
                    begin
                        pos_next = pos_inc;
                    end
                    else if (is_pad)
                    begin
                        if (fill_reg < 2'd2)
                        begin
                            job.fin    = 1'b1;
                            job.failed = 1'b1;
                        end
                        else
                        begin
                            pos_next   = pos_inc;
                            phase_next = (fill_reg == 2'd2) ? PH_WANT_PAD : PH_AFTER;
                        end
                    end
                    else if (sx[6])
                    begin
                        job.fin    = 1'b1;
                        job.failed = 1'b1;
                    end
                    else if ((room == 32'd1 && fill_reg == 2'd2) ||
                             (room == 32'd2 && fill_reg == 2'd3))
                    begin
                        // next chunk part would not fit the byte cap
                        job.fin = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (fill_reg != 2'd3)
                        begin
                            store_next[fill_reg] = sx[5:0];
                            fill_next            = fill_reg + 2'd1;
                        end
                        else
                        begin
                            job.nbytes     = 2'd3;
                            fill_next      = 2'd0;
                            committed_next = pos_inc;
                            emitted_next   = emitted_plus3;
                            if (emitted_plus3 == limit_reg)
                            begin
                                job.fin      = 1'b1;
                                job.err_pos  = pos_inc;
                                job.rd_count = pos_inc;
                                job.total    = emitted_plus3;
                            end
                        end
                    end
                end
                default: ;
            endcase
            // a finish report closes the string until the end marker
            if (job.fin) phase_next = PH_DONE;
        end
        else
        begin
            case (phase_reg)
                PH_DONE: ;
                PH_WANT_PAD:
                begin
                    job.fin    = 1'b1;
                    job.failed = !stop_mode;
                end
                PH_AFTER:
                begin
                    job.fin = 1'b1;
                    if (mode_reg == MODE_STRICT && extra_bits)
                    begin
                        job.failed = 1'b1;
                    end
                    else
                    begin
                        job.nbytes   = part_nb;
                        job.rd_count = pos_reg;
                        job.total    = emitted_reg + {30'd0, part_nb};
                    end
                end
                PH_COLLECT:
                begin
                    job.fin = 1'b1;
                    if (limit_reg == 32'd0)
                    begin
                        job.rd_count = 32'd0;
                    end
                    else if (fill_reg == 2'd0 || stop_mode)
                    begin
                        job.failed = 1'b0;
                    end
                    else if (fill_reg == 2'd1 || mode_reg == MODE_STRICT)
                    begin
                        job.failed = 1'b1;
                    end
                    else
                    begin
                        job.nbytes   = part_nb;
                        job.rd_count = pos_reg;
                        job.total    = emitted_reg + {30'd0, part_nb};
                    end
                end
                default: ;
            endcase
            phase_next     = PH_COLLECT;
            fill_next      = 2'd0;
            pos_next       = 32'd0;
            committed_next = 32'd0;
            emitted_next   = 32'd0;
        end

        job_push = accept && (job.fin || job.nbytes != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COLLECT;
            fill_reg      <= 2'd0;
            pos_reg       <= 32'd0;
            committed_reg <= 32'd0;
            emitted_reg   <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            committed_reg <= committed_next;
            emitted_reg   <= emitted_next;
        end
    end

    // sextets are only read under fill_reg
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store_reg <= store_next;
        end
    end

endmodule

### sv/b64dec_queue.sv
module b64dec_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  b64dec_pkg::job_t      push_job,
    input  logic                  pop,
    output b64dec_pkg::job_t      head,
    output logic                  empty,
    output logic                  full,
    output logic [b64dec_pkg::QCNT_W-1:0] count
);
    import b64dec_pkg::*;

    job_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign empty   = (count_reg == QCNT_W'(0));
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign count   = count_reg;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + QCNT_W'(1);
        if (!do_push && do_pop) count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/b64dec_back.sv
module b64dec_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64dec_pkg::job_t      head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  kind,
    output logic [7:0]            data_byte,
    output logic                  failed,
    output logic [31:0]           error_position,
    output logic [31:0]           read_count,
    output logic [31:0]           bytes_total,
    output logic                  last
);
    import b64dec_pkg::*;

    logic        valid_reg;
    logic [1:0]  idx_reg;
    logic        kind_reg, failed_reg, last_reg;
    logic [7:0]  byte_reg;
    logic [31:0] pos_reg, rd_reg, total_reg;

    logic        load;
    logic [2:0]  n_res;
    logic [1:0]  last_idx;
    logic        is_data;
    logic [7:0]  sel_byte;

    always_comb
    begin
        load     = (!valid_reg || !result_stall) && !empty;
        n_res    = {1'b0, head.nbytes} + {2'b00, head.fin} - 3'd1;
        last_idx = n_res[1:0];
        is_data  = (idx_reg < head.nbytes);
        case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            2'd2:    sel_byte = head.bytes[2];
            default: sel_byte = 8'd0;
        endcase
        pop = load && (idx_reg == last_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= pop ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= is_data ? KIND_DATA : KIND_FINISH;
            byte_reg   <= is_data ? sel_byte : 8'd0;
            failed_reg <= !is_data && head.failed;
            pos_reg    <= is_data ? 32'd0 : head.err_pos;
            rd_reg     <= is_data ? 32'd0 : head.rd_count;
            total_reg  <= is_data ? 32'd0 : head.total;
            last_reg   <= !is_data;
        end
    end

    assign result_valid   = valid_reg;
    assign kind           = kind_reg;
    assign data_byte      = byte_reg;
    assign failed         = failed_reg;
    assign error_position = pos_reg;
    assign read_count     = rd_reg;
    assign bytes_total    = total_reg;
    assign last           = last_reg;

endmodule

### dv/tb_base64_chunked_decoder_with_limits_top.sv
`timescale 1ns / 1ps

module tb_base64_chunked_decoder_with_limits_top;
    import b64dec_pkg::*;

    // Run length and time-out
    localparam int RANDOM_ITEMS  = 330;
    localparam int PHASE_ITEMS   = 40;
    localparam int SETTLE_CYCLES = 8;      // output is registered behind the queue
    localparam int LONG_HOLD     = 120;    // receiver hold-off, fills the queue
    localparam int CYCLE_LIMIT   = 200000;

    // Mode code the block does not name; it must act as loose
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [6:0] NO_SEXTET = 7'd64;

    // Scanner phases of one string
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_WANT_PAD,
        ST_AFTER_PAD,
        ST_DONE
    } scan_phase_t;

    // Shapes of the last chunk of a random string
    typedef enum int {
        TAIL_NONE,
        TAIL_PAD2,       // two sextets then "=="
        TAIL_PAD1,       // three sextets then "="
        TAIL_ONE,
        TAIL_TWO,
        TAIL_THREE,
        TAIL_HALF_PAD    // two sextets then a lone "="
    } tail_t;

    // Damage applied to a random string
    typedef enum int {
        FLAW_NOISE,      // arbitrary code unit somewhere
        FLAW_PAD,        // '=' somewhere
        FLAW_JUNK,       // alphabet char appended (junk after padding if padded)
        FLAW_ALPHABET,   // 62/63 of the other alphabet
        FLAW_NONE
    } flaw_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        failed;
        logic [31:0] err_pos;
        logic [31:0] rd_count;
        logic [31:0] total;
        logic        last;
    } b64_result_t;

    // Decoder predictor plus the queue of results still to come.
    class b64_scoreboard;
        bit          url;
        logic [1:0]  mode;
        logic [31:0] limit;
        logic [5:0]  sx [3];
        logic [1:0]  fill;
        scan_phase_t phase;
        logic [31:0] pos;
        logic [31:0] committed;
        logic [31:0] emitted;
        b64_result_t awaited [$];
        int          errors;

        function new();
            url    = 1'b0;
            mode   = MODE_LOOSE;
            limit  = LIMIT_RESET;
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            sx[0] = '0; sx[1] = '0; sx[2] = '0;
            fill      = '0;
            phase     = ST_COLLECT;
            pos       = '0;
            committed = '0;
            emitted   = '0;
        endfunction

        function void set_cfg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_URL:   url   = data[0];
                CFG_MODE:  mode  = data[1:0];
                CFG_LIMIT: limit = data;
                default: ;
            endcase
        endfunction

        function bit is_space(logic [15:0] c);
            return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE;
        endfunction

        function logic [6:0] sextet_of(logic [15:0] c);
            if (c >= CH_UP_A && c <= CH_UP_Z) return 7'(c - CH_UP_A);
            if (c >= CH_LO_A && c <= CH_LO_Z) return 7'(c - CH_LO_A + 26);
            if (c >= CH_D0 && c <= CH_D9) return 7'(c - CH_D0 + 52);
            if (url)
            begin
                if (c == CH_MINUS) return {1'b0, SEXTET_62};
                if (c == CH_UNDER) return {1'b0, SEXTET_63};
            end
            else
            begin
                if (c == CH_PLUS)  return {1'b0, SEXTET_62};
                if (c == CH_SLASH) return {1'b0, SEXTET_63};
            end
            return NO_SEXTET;
        endfunction

        function void push_byte(logic [7:0] b);
            b64_result_t r;
            r = '0;
            r.kind      = KIND_DATA;
            r.data_byte = b;
            awaited.insert(awaited.size(), r);
            emitted++;
        endfunction

        function void push_finish(logic f, logic [31:0] rd);
            b64_result_t r;
            r = '0;
            r.kind     = KIND_FINISH;
            r.failed   = f;
            r.err_pos  = pos;
            r.rd_count = rd;
            r.total    = emitted;
            r.last     = 1'b1;
            awaited.insert(awaited.size(), r);
            phase = ST_DONE;
        endfunction

        // bytes of a chunk cut short with two or three sextets
        function void push_partial();
            push_byte({sx[0], sx[1][5:4]});
            if (fill == 2'd3) push_byte({sx[1][3:0], sx[2][5:2]});
        endfunction

        function void predict_char(logic [15:0] c);
            logic [6:0]  v;
            logic [31:0] room;
            if (phase == ST_DONE) return;
            if (phase == ST_COLLECT && limit == 0)
            begin
                push_finish(1'b0, '0);
                return;
            end
            if (is_space(c))
            begin
                pos++;
                return;
            end
            if (phase == ST_AFTER_PAD)
            begin
                push_finish(1'b1, committed);
                return;
            end
            if (phase == ST_WANT_PAD)
            begin
                if (c == CH_PAD)
                begin
                    pos++;
                    phase = ST_AFTER_PAD;
                end
                else
                begin
                    push_finish(mode != MODE_STOP, committed);
                end
                return;
            end
            if (c == CH_PAD)
            begin
                if (fill < 2)
                begin
                    push_finish(1'b1, committed);
                end
                else
                begin
                    pos++;
                    phase = (fill == 2'd2) ? ST_WANT_PAD : ST_AFTER_PAD;
                end
                return;
            end
            v    = sextet_of(c);
            room = limit - emitted;
            if (v == NO_SEXTET)
            begin
                push_finish(1'b1, committed);
                return;
            end
            // cap: the next chunk part would not fit
            if ((room == 1 && fill == 2'd2) || (room == 2 && fill == 2'd3))
            begin
                push_finish(1'b0, committed);
                return;
            end
            pos++;
            if (fill < 3)
            begin
                sx[fill] = v[5:0];
                fill++;
                return;
            end
            push_byte({sx[0], sx[1][5:4]});
            push_byte({sx[1][3:0], sx[2][5:2]});
            push_byte({sx[2][1:0], v[5:0]});
            fill      = '0;
            committed = pos;
            if (emitted == limit) push_finish(1'b0, committed);
        endfunction

        function void predict_end();
            bit extra;
            if (phase == ST_DONE) return;
            if (phase == ST_COLLECT)
            begin
                if (limit == 0)
                    push_finish(1'b0, '0);
                else if (fill == 0 || mode == MODE_STOP)
                    push_finish(1'b0, committed);
                else if (fill == 1 || mode == MODE_STRICT)
                    push_finish(1'b1, committed);
                else
                begin
                    push_partial();
                    push_finish(1'b0, pos);
                end
                return;
            end
            if (phase == ST_WANT_PAD)
            begin
                push_finish(mode != MODE_STOP, committed);
                return;
            end
            // padded chunk: strict mode rejects nonzero leftover bits
            extra = (fill == 2'd2) ? (sx[1][3:0] != 0) : (sx[2][1:0] != 0);
            if (mode == MODE_STRICT && extra)
            begin
                push_finish(1'b1, committed);
                return;
            end
            push_partial();
            push_finish(1'b0, pos);
        endfunction

        function void note_item(logic c_cmd, logic [15:0] c);
            if (c_cmd == CMD_END)
            begin
                predict_end();
                clear_string();
            end
            else
            begin
                predict_char(c);
            end
        endfunction

        function void check_result(b64_result_t got);
            b64_result_t w;
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: kind %0d byte %0h", got.kind,
                       got.data_byte);
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (got.kind != w.kind)
            begin
                $error("kind: expected %0d, got %0d", w.kind, got.kind);
                errors++;
            end
            if (got.data_byte != w.data_byte)
            begin
                $error("data_byte: expected %0h, got %0h", w.data_byte, got.data_byte);
                errors++;
            end
            if (got.failed != w.failed)
            begin
                $error("failed: expected %0d, got %0d", w.failed, got.failed);
                errors++;
            end
            if (got.err_pos != w.err_pos)
            begin
                $error("error_position: expected %0d, got %0d", w.err_pos, got.err_pos);
                errors++;
            end
            if (got.rd_count != w.rd_count)
            begin
                $error("read_count: expected %0d, got %0d", w.rd_count, got.rd_count);
                errors++;
            end
            if (got.total != w.total)
            begin
                $error("bytes_total: expected %0d, got %0d", w.total, got.total);
                errors++;
            end
            if (got.last != w.last)
            begin
                $error("last: expected %0d, got %0d", w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // DUT hookup
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic        cmd;
    logic [15:0] ch;
    logic        result_valid;
    logic        result_stall;
    logic        kind;
    logic [7:0]  data_byte;
    logic        failed;
    logic [31:0] error_position;
    logic [31:0] read_count;
    logic [31:0] bytes_total;
    logic        last;

    base64_chunked_decoder_with_limits_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .cmd            (cmd),
        .ch             (ch),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .data_byte      (data_byte),
        .failed         (failed),
        .error_position (error_position),
        .read_count     (read_count),
        .bytes_total    (bytes_total),
        .last           (last)
    );

    b64_scoreboard board;
    bit            no_idle;       // both sides run back to back while set
    int            hold_cycles;   // one-shot long hold-off for the receiver
    int            items_sent;
    int            cycle_count = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Monitor: everything is sampled at the edge, before any NBA lands, so
    // both sides see the same pre-edge values. Results are checked before
    // the request of the same edge is noted; a result can never stem from a
    // request accepted at that very edge.
    always @(posedge clk)
    begin
        b64_result_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.kind      = kind;
            got.data_byte = data_byte;
            got.failed    = failed;
            got.err_pos   = error_position;
            got.rd_count  = read_count;
            got.total     = bytes_total;
            got.last      = last;
            board.check_result(got);
        end
        if (rst_n && item_valid && !item_stall)
            board.note_item(cmd, ch);
    end

    // Receiver: a random stall before each result, or one long
    // hold-off when asked, counted here in cycles.
    initial
    begin
        int n;
        result_stall = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = no_idle ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    function automatic logic [15:0] sextet_char(logic [5:0] v, bit url_sel);
        if (v < 26) return CH_UP_A + 16'(v);
        if (v < 52) return CH_LO_A + 16'(v - 26);
        if (v < 62) return CH_D0 + 16'(v - 52);
        if (v == SEXTET_62) return url_sel ? CH_MINUS : CH_PLUS;
        return url_sel ? CH_UNDER : CH_SLASH;
    endfunction

    function automatic logic [15:0] pick_space();
        case ($urandom_range(0, 4))
            0:       return CH_TAB;
            1:       return CH_LF;
            2:       return CH_FF;
            3:       return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    // append one code unit to the end of a string under construction
    function automatic void add_unit(ref logic [15:0] q [$], input logic [15:0] v);
        q.insert(q.size(), v);
    endfunction

    // One request on the item channel: optional gap, then hold until taken.
    task automatic send_item(input logic c_cmd, input logic [15:0] c);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c_cmd;
        ch         <= c;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic send_end();
        send_item(CMD_END, 16'($urandom));
    endtask

    // Sender pause: let the last request be noted, wait until nothing is in
    // flight, then wait SETTLE_CYCLES for requests that produce no result.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_cfg(idx, data);
    endtask

    task automatic configure(input bit url_sel, input logic [1:0] mode_sel,
                             input logic [31:0] lim);
        settle();
        write_cfg(CFG_URL, {31'd0, url_sel});
        write_cfg(CFG_MODE, {30'd0, mode_sel});
        write_cfg(CFG_LIMIT, lim);
    endtask

    // Mostly well-formed text with random content, random tails, spaces
    // sprinkled in, and now and then some damage.
    task automatic send_random_string();
        logic [15:0] raw [$];
        logic [15:0] text [$];
        logic [5:0]  s;
        int          nchunks;
        tail_t       tail;
        flaw_t       flaw;
        int          at;
        bit          url_now;
        url_now = board.url;
        nchunks = $urandom_range(0, 3);
        repeat (nchunks * 4) add_unit(raw, sextet_char(6'($urandom), url_now));
        tail = tail_t'($urandom_range(0, 6));
        case (tail)
            TAIL_PAD2:
            begin
                add_unit(raw, sextet_char(6'($urandom), url_now));
                s = 6'($urandom);
                if ($urandom_range(0, 1)) s[3:0] = '0;
                add_unit(raw, sextet_char(s, url_now));
                add_unit(raw, CH_PAD);
                add_unit(raw, CH_PAD);
            end
            TAIL_PAD1:
            begin
                add_unit(raw, sextet_char(6'($urandom), url_now));
                add_unit(raw, sextet_char(6'($urandom), url_now));
                s = 6'($urandom);
                if ($urandom_range(0, 1)) s[1:0] = '0;
                add_unit(raw, sextet_char(s, url_now));
                add_unit(raw, CH_PAD);
            end
            TAIL_ONE:
                add_unit(raw, sextet_char(6'($urandom), url_now));
            TAIL_TWO, TAIL_HALF_PAD:
            begin
                add_unit(raw, sextet_char(6'($urandom), url_now));
                add_unit(raw, sextet_char(6'($urandom), url_now));
                if (tail == TAIL_HALF_PAD) add_unit(raw, CH_PAD);
            end
            TAIL_THREE:
                repeat (3) add_unit(raw, sextet_char(6'($urandom), url_now));
            default: ;
        endcase
        flaw = ($urandom_range(0, 3) == 0) ? flaw_t'($urandom_range(0, 3)) : FLAW_NONE;
        at   = (raw.size() == 0) ? 0 : $urandom_range(0, raw.size() - 1);
        if (raw.size() == 0 && flaw != FLAW_NONE && flaw != FLAW_JUNK)
            add_unit(raw, CH_UP_A);
        case (flaw)
            FLAW_NOISE:    raw[at] = 16'($urandom);
            FLAW_PAD:      raw[at] = CH_PAD;
            FLAW_JUNK:     add_unit(raw, sextet_char(6'($urandom), url_now));
            FLAW_ALPHABET:
                if (url_now) raw[at] = $urandom_range(0, 1) ? CH_PLUS : CH_SLASH;
                else         raw[at] = $urandom_range(0, 1) ? CH_MINUS : CH_UNDER;
            default: ;
        endcase
        foreach (raw[i])
        begin
            if ($urandom_range(0, 5) == 0) add_unit(text, pick_space());
            add_unit(text, raw[i]);
        end
        if ($urandom_range(0, 5) == 0) add_unit(text, pick_space());
        foreach (text[i]) send_item(CMD_CHAR, text[i]);
        send_end();
    endtask

    initial
    begin
        int rand_base;
        int phase_base;
        int phase_idx;
        bit url_sel;
        logic [1:0]  mode_sel;
        logic [31:0] lim;

        board       = new();
        no_idle     = 1'b0;
        hold_cycles = 0;
        items_sent  = 0;
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_URL;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        cmd        <= CMD_CHAR;
        ch         <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset config: 62/63 of the standard alphabet and the
        // ends of the digit and lower-case ranges in one full chunk
        send_item(CMD_CHAR, CH_PLUS);
        send_item(CMD_CHAR, CH_SLASH);
        send_item(CMD_CHAR, CH_D9);
        send_item(CMD_CHAR, CH_LO_Z);
        send_end();
        // '=' with only one sextet
        send_item(CMD_CHAR, "Q");
        send_item(CMD_CHAR, CH_PAD);
        send_end();   // after finish: no result
        // lone '=' then space then junk where the second '=' belongs
        send_item(CMD_CHAR, CH_UP_A);
        send_item(CMD_CHAR, CH_UP_A);
        send_item(CMD_CHAR, CH_PAD);
        send_item(CMD_CHAR, CH_SPACE);
        send_item(CMD_CHAR, "x");
        send_end();
        // code unit far outside the alphabet
        send_item(CMD_CHAR, 16'hFFFF);
        send_end();
        // URL alphabet, strict: padded chunk with leftover bits set
        configure(1'b1, MODE_STRICT, LIMIT_RESET);
        send_item(CMD_CHAR, CH_MINUS);
        send_item(CMD_CHAR, CH_UNDER);
        send_item(CMD_CHAR, CH_UP_Z);
        send_item(CMD_CHAR, CH_PAD);
        send_end();
        // zero byte limit finishes on the first item
        configure(1'b1, MODE_STRICT, 32'd0);
        send_item(CMD_CHAR, CH_UP_A);
        send_end();

        // Random phases; the first few pin the extremes of each register
        rand_base = items_sent;
        phase_idx = 0;
        while (items_sent - rand_base < RANDOM_ITEMS)
        begin
            case (phase_idx)
                0:       begin url_sel = 1'b1; mode_sel = MODE_LOOSE;  lim = LIMIT_RESET; end
                1:       begin url_sel = 1'b0; mode_sel = MODE_STRICT; lim = LIMIT_RESET; end
                2:       begin url_sel = 1'b1; mode_sel = MODE_STOP;   lim = 32'd1;       end
                3:       begin url_sel = 1'b0; mode_sel = MODE_SPARE;  lim = 32'd0;       end
                4:       begin url_sel = 1'b0; mode_sel = MODE_STRICT; lim = 32'd2;       end
                default:
                begin
                    url_sel  = 1'($urandom);
                    mode_sel = 2'($urandom);
                    lim      = ($urandom_range(0, 2) == 0) ? LIMIT_RESET
                                                           : 32'($urandom_range(1, 9));
                end
            endcase
            configure(url_sel, mode_sel, lim);
            // back-to-back traffic on some phases; the first one also has
            // the receiver hold off long enough that item_stall must rise
            no_idle = (phase_idx % 3 == 0);
            if (phase_idx == 0) hold_cycles = LONG_HOLD;
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS &&
                   items_sent - rand_base < RANDOM_ITEMS)
                send_random_string();
            phase_idx++;
        end
        no_idle = 1'b0;

        settle();
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
